@@ src/segment_display_controller_core_assert.svh @@
// Assertion macros for the segment display controller checker
`ifndef SEGMENT_DISPLAY_CONTROLLER_CORE_ASSERT_SVH
`define SEGMENT_DISPLAY_CONTROLLER_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define SDC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define SDC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ src/sdc_pkg.sv @@
// Shared types, constants and glyph functions for the segment display controller
package sdc_pkg;
  localparam int NUM_POSITIONS = 13;
  localparam int NUM_OUT_BYTES = 16;
  localparam int BYTE_IDX_W = 4;

  localparam logic [1:0] CMD_CHAR   = 2'd0;
  localparam logic [1:0] CMD_RAW    = 2'd1;
  localparam logic [1:0] CMD_REFR   = 2'd2;
  localparam logic [1:0] CMD_BRIGHT = 2'd3;

  localparam logic [7:0] BYTE_MODE   = 8'h40;
  localparam logic [7:0] BYTE_ADDR   = 8'hc0;
  localparam logic [7:0] BYTE_BRIGHT = 8'h88;

  // Item passed from the front part to the back part
  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  position;
    logic [7:0]  char_code;
    logic [15:0] raw_word;
    logic [1:0]  brightness_level;
  } item_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       frame_end;
    logic       last;
  } res_t;

  function automatic logic [15:0] font16(input logic [5:0] idx);
    logic [15:0] g;
    case (idx)
      6'd1: g = 16'h243f; 6'd2: g = 16'h0006; 6'd3: g = 16'h00db; 6'd4: g = 16'h00cf;
      6'd5: g = 16'h00e6; 6'd6: g = 16'h00ed; 6'd7: g = 16'h00fd; 6'd8: g = 16'h0007;
      6'd9: g = 16'h00ff; 6'd10: g = 16'h00ef; 6'd11: g = 16'h00f7; 6'd12: g = 16'h128f;
      6'd13: g = 16'h0039; 6'd14: g = 16'h120f; 6'd15: g = 16'h00f9; 6'd16: g = 16'h00f1;
      6'd17: g = 16'h00bd; 6'd18: g = 16'h00f6; 6'd19: g = 16'h1209; 6'd20: g = 16'h001e;
      6'd21: g = 16'h0c70; 6'd22: g = 16'h0038; 6'd23: g = 16'h0536; 6'd24: g = 16'h0936;
      6'd25: g = 16'h003f; 6'd26: g = 16'h00f3; 6'd27: g = 16'h083f; 6'd28: g = 16'h08f3;
      6'd29: g = 16'h00ed; 6'd30: g = 16'h1201; 6'd31: g = 16'h003e; 6'd32: g = 16'h2430;
      6'd33: g = 16'h2836; 6'd34: g = 16'h2d00; 6'd35: g = 16'h00ee; 6'd36: g = 16'h2409;
      6'd37: g = 16'h00c0; 6'd38: g = 16'h2400; 6'd39: g = 16'h12c0;
      default: g = 16'h0000;
    endcase
    return g;
  endfunction

  function automatic logic [15:0] glyph16(input logic [7:0] c);
    logic [5:0] idx;
    idx = 6'd0;
    if (c >= "0" && c <= "9") idx = 6'(c - 8'h30 + 8'd1);
    else if (c >= "a" && c <= "z") idx = 6'(c - 8'h61 + 8'd11);
    else if (c >= "A" && c <= "Z") idx = 6'(c - 8'h41 + 8'd11);
    else if (c == "-") idx = 6'd37;
    else if (c == "/") idx = 6'd38;
    else if (c == "+") idx = 6'd39;
    return font16(idx);
  endfunction

  function automatic logic [15:0] glyph7(input logic [7:0] c);
    logic [15:0] g;
    if (c >= "0" && c <= "9") g = font16(6'(c - 8'h30 + 8'd1));
    else begin
      case (c)
        "-": g = 16'h00c0;
        "A": g = 16'h00f7;
        "B": g = 16'h007c;
        "C": g = 16'h0039;
        "D": g = 16'h00de;
        "E": g = 16'h00f9;
        "F": g = 16'h00f1;
        "G": g = 16'h00ef;
        "I": g = 16'h0006;
        "H": g = 16'h00f6;
        "L": g = 16'h0038;
        "N": g = 16'h0037;
        "O": g = 16'h003f;
        "P": g = 16'h00f3;
        "R", "r": g = 16'h0050;
        "S": g = 16'h00ed;
        "T", "t": g = 16'h00f8;
        "U": g = 16'h003e;
        "Y": g = 16'h006e;
        default: g = 16'h0000;
      endcase
    end
    return g;
  endfunction

  function automatic logic [7:0] bright_byte(input logic [1:0] lvl);
    logic [7:0] v;
    case (lvl)
      2'd0: v = 8'h00;
      2'd1: v = 8'h02;
      default: v = 8'h07;
    endcase
    return BYTE_BRIGHT | v;
  endfunction

  // Scatter the whole buffer through the panel wiring into one byte
  function automatic logic [7:0] wire_byte(input logic [NUM_POSITIONS*16-1:0] buf_flat,
                                           input logic [BYTE_IDX_W-1:0] k);
    logic [7:0] r;
    logic [15:0] w;
    logic [4:0] dst [14];
    logic [7:0] mask;
    logic [4:0] cnt;
    r = 8'h00;
    for (int p = 0; p < NUM_POSITIONS; p++) begin
      w = buf_flat[p*16 +: 16];
      for (int i = 0; i < 14; i++) dst[i] = 5'd31;
      cnt = 5'd0;
      case (p)
        0, 1, 2, 3, 4, 5, 6: begin
          dst[0] = 5'd14; dst[1] = 5'd7; dst[2] = 5'd0; dst[3] = 5'd3;
          dst[4] = 5'd11; dst[5] = 5'd15; dst[6] = 5'd9; dst[7] = 5'd6;
          dst[8] = 5'd13; dst[9] = 5'd12; dst[10] = 5'd5; dst[11] = 5'd1;
          dst[12] = 5'd2; dst[13] = 5'd8;
        end
        7, 9: begin
          dst[0] = 5'd5; dst[1] = 5'd12; dst[2] = 5'd13; dst[3] = 5'd6;
        end
        8: begin
          dst[0] = 5'd1; dst[1] = 5'd5; dst[2] = 5'd12; dst[3] = 5'd13; dst[4] = 5'd6;
        end
        10: begin
          dst[0] = 5'd11; dst[1] = 5'd3; dst[2] = 5'd0; dst[3] = 5'd7; dst[4] = 5'd14;
        end
        11: begin
          dst[0] = 5'd13; dst[1] = 5'd6; dst[2] = 5'd9; dst[3] = 5'd15;
        end
        default: begin
          dst[0] = 5'd8; dst[1] = 5'd2; dst[2] = 5'd1; dst[3] = 5'd5; dst[4] = 5'd12;
        end
      endcase
      case (p)
        0: begin mask = 8'h08; cnt = 5'd14; end
        1: begin mask = 8'h20; cnt = 5'd14; end
        2: begin mask = 8'h10; cnt = 5'd14; end
        3: begin mask = 8'h04; cnt = 5'd7; end
        4: begin mask = 8'h80; cnt = 5'd7; end
        5: begin mask = 8'h02; cnt = 5'd7; end
        6: begin mask = 8'h01; cnt = 5'd12; end
        7: begin mask = 8'h04; cnt = 5'd4; end
        8: begin mask = 8'h80; cnt = 5'd5; end
        9: begin mask = 8'h02; cnt = 5'd4; end
        10: begin mask = 8'h40; cnt = 5'd5; end
        11: begin mask = 8'h40; cnt = 5'd4; end
        default: begin mask = 8'h40; cnt = 5'd5; end
      endcase
      for (int b = 0; b < 14; b++)
        if (5'(b) < cnt && w[b] && dst[b] == {1'b0, k}) r = r | mask;
    end
    if (k == 4'd10) begin
      if (buf_flat[6*16 + 12]) r = r | 8'h20;
      if (buf_flat[6*16 + 13]) r = r | 8'h10;
      if (buf_flat[6*16 + 14]) r = r | 8'h04;
    end
    return r;
  endfunction
endpackage

@@ src/sdc_queue.sv @@
// Two-entry queue between the command front part and the byte back part
module sdc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  sdc_pkg::item_t wr_item,
  output logic           rd_valid,
  input  logic           rd_ready,
  output sdc_pkg::item_t rd_item
);
  import sdc_pkg::*;
  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rp_r];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_item;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end
endmodule

@@ src/sdc_back.sv @@
// Back part: holds the show buffer and emits driver bytes
module sdc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  sdc_pkg::item_t q_item,
  output logic           res_valid,
  input  logic           res_ready,
  output sdc_pkg::res_t  res
);
  import sdc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001, ST_ADDR = 3'b010, ST_DATA = 3'b100
  } state_t;

  state_t          st_r, st_nxt;
  logic [15:0]     buf_r [NUM_POSITIONS];
  logic [NUM_POSITIONS*16-1:0] buf_flat;
  logic [BYTE_IDX_W-1:0] idx_r, idx_nxt;
  logic            ov_r, ov_nxt;
  res_t            ob_r, ob_nxt;
  logic            slot_free;
  logic            take;

  always_comb begin
    for (int p = 0; p < NUM_POSITIONS; p++) buf_flat[p*16 +: 16] = buf_r[p];
  end

  assign slot_free = !ov_r || res_ready;
  assign q_ready   = (st_r == ST_IDLE) && slot_free;
  assign take      = q_valid && q_ready;
  assign res_valid = ov_r;
  assign res       = ob_r;

  // Update the show buffer on write commands
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_POSITIONS; p++) buf_r[p] <= 16'h0000;
    end else if (take) begin
      if (q_item.cmd == CMD_CHAR) begin
        if (q_item.position < 4'd3) buf_r[q_item.position] <= glyph16(q_item.char_code);
        else if (q_item.position < 4'd6)
          buf_r[q_item.position] <= glyph7(q_item.char_code);
      end else if (q_item.cmd == CMD_RAW && q_item.position < 4'(NUM_POSITIONS)) begin
        buf_r[q_item.position] <= q_item.raw_word;
      end
    end
  end

  // Sequence the output bytes
  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    ov_nxt  = ov_r && !res_ready;
    ob_nxt  = ob_r;
    case (st_r)
      ST_IDLE: begin
        if (take && q_item.cmd == CMD_REFR) begin
          ov_nxt = 1'b1;
          ob_nxt = '{bus_byte: BYTE_MODE, frame_end: 1'b1, last: 1'b0};
          st_nxt = ST_ADDR;
        end else if (take && q_item.cmd == CMD_BRIGHT) begin
          ov_nxt = 1'b1;
          ob_nxt = '{bus_byte: bright_byte(q_item.brightness_level),
                     frame_end: 1'b1, last: 1'b1};
        end
      end
      ST_ADDR: begin
        if (slot_free) begin
          ov_nxt  = 1'b1;
          ob_nxt  = '{bus_byte: BYTE_ADDR, frame_end: 1'b0, last: 1'b0};
          idx_nxt = '0;
          st_nxt  = ST_DATA;
        end
      end
      ST_DATA: begin
        if (slot_free) begin
          ov_nxt  = 1'b1;
          ob_nxt  = '{bus_byte: wire_byte(buf_flat, idx_r),
                      frame_end: (idx_r == 4'(NUM_OUT_BYTES - 1)),
                      last: (idx_r == 4'(NUM_OUT_BYTES - 1))};
          idx_nxt = idx_r + 1'b1;
          if (idx_r == 4'(NUM_OUT_BYTES - 1)) st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Hold the output register until transfer
  always_ff @(posedge clk) begin
    ob_r  <= ob_nxt;
    idx_r <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
    end
  end
endmodule

@@ src/segment_display_controller_core.sv @@
// Top level of the segment display controller
// A write command updates the show buffer in the back part and gives no byte. A refresh gives
// 18 bytes, one per cycle while out_tready is high; brightness gives one byte.
// A two-entry command queue lets new commands be taken while the byte sequencer
// is busy; the sustained rate is set by that sequencer.
module segment_display_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] cmd, [5:2] position, [13:6] char_code, [29:14] raw_word,
  // [31:30] brightness_level
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] bus_byte
  output logic        out_tuser,   // [0] frame_end
  output logic        out_tlast
);
  import sdc_pkg::*;
  item_t in_item, q_item;
  res_t  res;
  logic  q_valid, q_ready;

  assign in_item = '{cmd: in_tdata[1:0], position: in_tdata[5:2], char_code: in_tdata[13:6],
                     raw_word: in_tdata[29:14], brightness_level: in_tdata[31:30]};

  sdc_queue u_queue (
    .clk, .rst_n, .wr_valid(in_tvalid), .wr_ready(in_tready), .wr_item(in_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
  );

  sdc_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );

  assign out_tdata = res.bus_byte;
  assign out_tuser = res.frame_end;
  assign out_tlast = res.last;
endmodule

@@ src/sdc_checker.sv @@
// Port-level checker for the segment display controller
`include "segment_display_controller_core_assert.svh"
module sdc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);
  `SDC_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `SDC_ASSERT_IMP(a_last_ends, clk, rst_n, out_tvalid && out_tlast, out_tuser)
  // A frame end that is not the last byte can only be the mode byte
  `SDC_ASSERT_IMP(a_mode_nolast, clk, rst_n, out_tvalid && out_tuser && !out_tlast,
    out_tdata == 8'h40)
  `SDC_ASSERT_NXT(a_after_mode, clk, rst_n,
    out_tvalid && out_tready && out_tuser && !out_tlast,
    out_tvalid && out_tdata == 8'hc0)
endmodule

bind segment_display_controller_core sdc_checker u_sdc_checker (.*);

@@ test/testbench.sv @@
// Self-checking testbench for the segment display controller core
module testbench;
  import sdc_pkg::*;

  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       frame_end;
    logic       last;
  } byte_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  logic [31:0] cmd_queue[$];
  byte_rec_t   byte_queue[$];
  logic [15:0] shadow_buf[NUM_POSITIONS];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          errors = 0;
  int          cycles = 0;
  // Accept flag of the last rising edge, used by the driver
  logic        in_tready_seen = 1'b0;

  segment_display_controller_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #4 clk = ~clk;

  // Sixteen-segment font word for a table index
  function automatic logic [15:0] font_word(int idx);
    logic [15:0] f[40];
    f = '{16'h0000,
          16'h243f, 16'h0006, 16'h00db, 16'h00cf, 16'h00e6, 16'h00ed, 16'h00fd,
          16'h0007, 16'h00ff, 16'h00ef,
          16'h00f7, 16'h128f, 16'h0039, 16'h120f, 16'h00f9, 16'h00f1, 16'h00bd,
          16'h00f6, 16'h1209, 16'h001e, 16'h0c70, 16'h0038, 16'h0536, 16'h0936,
          16'h003f, 16'h00f3, 16'h083f, 16'h08f3, 16'h00ed, 16'h1201, 16'h003e,
          16'h2430, 16'h2836, 16'h2d00, 16'h00ee, 16'h2409,
          16'h00c0, 16'h2400, 16'h12c0};
    return f[idx];
  endfunction

  function automatic logic [15:0] seg16_glyph(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return font_word(c - 8'h30 + 1);
    if (c >= 8'h61 && c <= 8'h7a) return font_word(c - 8'h61 + 11);
    if (c >= 8'h41 && c <= 8'h5a) return font_word(c - 8'h41 + 11);
    if (c == 8'h2d) return font_word(37);
    if (c == 8'h2f) return font_word(38);
    if (c == 8'h2b) return font_word(39);
    return 16'h0000;
  endfunction

  function automatic logic [15:0] seg7_glyph(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return font_word(c - 8'h30 + 1);
    case (c)
      8'h2d: return 16'h00c0;
      8'h41: return 16'h00f7;
      8'h42: return 16'h007c;
      8'h43: return 16'h0039;
      8'h44: return 16'h00de;
      8'h45: return 16'h00f9;
      8'h46: return 16'h00f1;
      8'h47: return 16'h00ef;
      8'h49: return 16'h0006;
      8'h48: return 16'h00f6;
      8'h4c: return 16'h0038;
      8'h4e: return 16'h0037;
      8'h4f: return 16'h003f;
      8'h50: return 16'h00f3;
      8'h52, 8'h72: return 16'h0050;
      8'h53: return 16'h00ed;
      8'h54, 8'h74: return 16'h00f8;
      8'h55: return 16'h003e;
      8'h59: return 16'h006e;
      default: return 16'h0000;
    endcase
  endfunction

  // Scatter the shadow buffer through the panel wiring
  task automatic panel_bytes(output logic [7:0] pb[NUM_OUT_BYTES]);
    int    main_dst[14];
    int    dst[14];
    int    cnt;
    logic [7:0] mask;
    main_dst = '{14, 7, 0, 3, 11, 15, 9, 6, 13, 12, 5, 1, 2, 8};
    for (int k = 0; k < NUM_OUT_BYTES; k++) pb[k] = 8'h00;
    for (int p = 0; p < NUM_POSITIONS; p++) begin
      dst = main_dst;
      case (p)
        0: begin cnt = 14; mask = 8'h08; end
        1: begin cnt = 14; mask = 8'h20; end
        2: begin cnt = 14; mask = 8'h10; end
        3: begin cnt = 7; mask = 8'h04; end
        4: begin cnt = 7; mask = 8'h80; end
        5: begin cnt = 7; mask = 8'h02; end
        6: begin cnt = 12; mask = 8'h01; end
        7: begin cnt = 4; mask = 8'h04; dst[0:3] = '{5, 12, 13, 6}; end
        8: begin cnt = 5; mask = 8'h80; dst[0:4] = '{1, 5, 12, 13, 6}; end
        9: begin cnt = 4; mask = 8'h02; dst[0:3] = '{5, 12, 13, 6}; end
        10: begin cnt = 5; mask = 8'h40; dst[0:4] = '{11, 3, 0, 7, 14}; end
        11: begin cnt = 4; mask = 8'h40; dst[0:3] = '{13, 6, 9, 15}; end
        default: begin cnt = 5; mask = 8'h40; dst[0:4] = '{8, 2, 1, 5, 12}; end
      endcase
      for (int b = 0; b < cnt; b++)
        if (shadow_buf[p][b]) pb[dst[b]] = pb[dst[b]] | mask;
    end
    if (shadow_buf[6][12]) pb[10] = pb[10] | 8'h20;
    if (shadow_buf[6][13]) pb[10] = pb[10] | 8'h10;
    if (shadow_buf[6][14]) pb[10] = pb[10] | 8'h04;
  endtask

  // Update the shadow buffer and queue the bytes a command produces
  task automatic predict_command(logic [31:0] word);
    logic [1:0]  cmd;
    logic [3:0]  pos;
    logic [7:0]  ch;
    logic [1:0]  lvl;
    logic [7:0]  pb[NUM_OUT_BYTES];
    logic [7:0]  lv;
    cmd = word[1:0];
    pos = word[5:2];
    ch  = word[13:6];
    lvl = word[31:30];
    case (cmd)
      CMD_CHAR: begin
        if (pos < 3) shadow_buf[pos] = seg16_glyph(ch);
        else if (pos < 6) shadow_buf[pos] = seg7_glyph(ch);
      end
      CMD_RAW: if (pos < NUM_POSITIONS) shadow_buf[pos] = word[29:14];
      CMD_REFR: begin
        panel_bytes(pb);
        byte_queue.push_back('{BYTE_MODE, 1'b1, 1'b0});
        byte_queue.push_back('{BYTE_ADDR, 1'b0, 1'b0});
        for (int k = 0; k < NUM_OUT_BYTES; k++)
          byte_queue.push_back('{pb[k], k == 15, k == 15});
      end
      default: begin
        lv = (lvl == 2'd0) ? 8'h00 : (lvl == 2'd1) ? 8'h02 : 8'h07;
        byte_queue.push_back('{BYTE_BRIGHT | lv, 1'b1, 1'b1});
      end
    endcase
  endtask

  function automatic logic [31:0] pack_cmd(logic [1:0] cmd, logic [3:0] pos,
                                           logic [7:0] ch, logic [15:0] raw,
                                           logic [1:0] lvl);
    return {lvl, raw, ch, pos, cmd};
  endfunction

  // Random command, mostly writes to the wired positions, with refreshes and brightness mixed in
  function automatic logic [31:0] random_cmd();
    logic [1:0] cmd;
    logic [3:0] pos;
    logic [7:0] ch;
    int sel;
    sel = $urandom_range(0, 99);
    cmd = (sel < 40) ? CMD_CHAR : (sel < 70) ? CMD_RAW : (sel < 88) ? CMD_REFR : CMD_BRIGHT;
    pos = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(13, 15))
                                      : 4'($urandom_range(0, 12));
    if (cmd == CMD_CHAR && $urandom_range(0, 3) != 0) pos = 4'($urandom_range(0, 5));
    ch = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(8'h2b, 8'h7a));
    return pack_cmd(cmd, pos, ch, 16'($urandom), 2'($urandom));
  endfunction

  // Driver: present queued commands at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready_seen) begin
        if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tdata  <= cmd_queue.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on input transfers, check output transfers
  always @(posedge clk) begin
    byte_rec_t exp_b;
    cycles <= cycles + 1;
    in_tready_seen <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) predict_command(in_tdata);
    if (rst_n && out_tvalid && out_tready) begin
      if (byte_queue.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10) $display("unexpected byte %h", out_tdata);
      end else begin
        exp_b = byte_queue.pop_front();
        if (exp_b.bus_byte !== out_tdata || exp_b.frame_end !== out_tuser ||
            exp_b.last !== out_tlast) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("mismatch: expected %h/%b/%b got %h/%b/%b", exp_b.bus_byte,
                     exp_b.frame_end, exp_b.last, out_tdata, out_tuser, out_tlast);
        end
      end
    end
    if (cycles >= LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Wait until the driver queue is empty and the last item was taken
  task automatic drain_stimulus();
    while (cmd_queue.size() > 0 || in_tvalid) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic wait_results();
    while (byte_queue.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    int pct_send[4];
    int pct_recv[4];
    pct_send = '{0, 49, 0, 25};
    pct_recv = '{0, 0, 49, 25};
    for (int p = 0; p < NUM_POSITIONS; p++) shadow_buf[p] = 16'h0000;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, every command, glyph special cases
    cmd_queue.push_back(pack_cmd(CMD_REFR, 4'd0, 8'h00, 16'h0000, 2'd0));
    for (int l = 0; l < 4; l++)
      cmd_queue.push_back(pack_cmd(CMD_BRIGHT, 4'd15, 8'hff, 16'hffff, 2'(l)));
    cmd_queue.push_back(pack_cmd(CMD_CHAR, 4'd0, "a", 16'h0, 2'd0));
    cmd_queue.push_back(pack_cmd(CMD_CHAR, 4'd1, "Z", 16'h0, 2'd0));
    cmd_queue.push_back(pack_cmd(CMD_CHAR, 4'd2, "+", 16'h0, 2'd0));
    cmd_queue.push_back(pack_cmd(CMD_CHAR, 4'd0, "/", 16'h0, 2'd0));
    cmd_queue.push_back(pack_cmd(CMD_CHAR, 4'd1, "-", 16'h0, 2'd0));
    cmd_queue.push_back(pack_cmd(CMD_CHAR, 4'd3, "r", 16'h0, 2'd0));
    cmd_queue.push_back(pack_cmd(CMD_CHAR, 4'd4, "t", 16'h0, 2'd0));
    cmd_queue.push_back(pack_cmd(CMD_CHAR, 4'd5, "a", 16'h0, 2'd0));
    cmd_queue.push_back(pack_cmd(CMD_CHAR, 4'd3, "9", 16'h0, 2'd0));
    cmd_queue.push_back(pack_cmd(CMD_CHAR, 4'd8, "A", 16'h0, 2'd0));
    cmd_queue.push_back(pack_cmd(CMD_CHAR, 4'd15, "A", 16'h0, 2'd0));
    cmd_queue.push_back(pack_cmd(CMD_REFR, 4'd15, 8'hff, 16'hffff, 2'd3));
    for (int p = 6; p < NUM_POSITIONS; p++)
      cmd_queue.push_back(pack_cmd(CMD_RAW, 4'(p), 8'h00, 16'hffff, 2'd0));
    cmd_queue.push_back(pack_cmd(CMD_RAW, 4'd14, 8'h00, 16'hffff, 2'd0));
    cmd_queue.push_back(pack_cmd(CMD_REFR, 4'd0, 8'h00, 16'h0000, 2'd0));
    drain_stimulus();
    // Hold off until every expected byte has come
    wait_results();

    // Random phases with different idle mixes
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = pct_send[ph];
      recv_stall_pct = pct_recv[ph];
      for (int i = 0; i < 62; i++) cmd_queue.push_back(random_cmd());
      drain_stimulus();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_results();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
